// ===== rtl/bed_pkg.sv =====
// Shared types and constants for the backslash escape decoder.
// No dependencies; used by bed_decode and backslash_escape_decoder.
package bed_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_OCT1   = 2'd2,
      MODE_OCT2   = 2'd3
   } mode_type;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_EIGHT  = 8'h38;

   // One decoded word.
   typedef struct packed {
      logic [7:0] data;
      logic       err;
      logic       eos;
   } rslt_type;

   // Up to two words produced by one input word.
   typedef struct packed {
      logic [1:0]     cnt;
      rslt_type [1:0] item;
   } bank_type;

endpackage

// ===== rtl/bed_decode.sv =====
// Escape decoding state machine: holds mode and octal accumulator,
// turns one accepted input word into zero to two result words. Uses bed_pkg.
module bed_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_final,
   output bed_pkg::bank_type bank
);

   bed_pkg::mode_type mode_ff, mode_in, mode_mid;
   logic [7:0]        oct_ff, oct_in, oct_mid;
   logic              is_oct;
   logic [7:0]        acc;
   logic              esc_hit;
   logic [7:0]        esc_code;

   // a third word from one input is dropped
   function automatic bed_pkg::bank_type push(bed_pkg::bank_type b,
                                              logic [7:0] d, logic e);
      bed_pkg::bank_type r;
      r = b;
      if (b.cnt != 2'd2) begin
         r.item[r.cnt[0]].data = e ? 8'h00 : d;
         r.item[r.cnt[0]].err  = e;
         r.item[r.cnt[0]].eos  = 1'b0;
         r.cnt = r.cnt + 2'd1;
      end
      return r;
   endfunction

   assign is_oct = (in_byte >= bed_pkg::CHAR_ZERO) && (in_byte < bed_pkg::CHAR_EIGHT);
   assign acc    = {oct_ff[4:0], in_byte[2:0]};

   always_comb begin
      esc_hit  = 1'b1;
      esc_code = 8'h00;
      case (in_byte)
         8'h6E:   esc_code = 8'h0A; // n
         8'h74:   esc_code = 8'h09; // t
         8'h72:   esc_code = 8'h0D; // r
         8'h61:   esc_code = 8'h07; // a
         8'h62:   esc_code = 8'h08; // b
         8'h66:   esc_code = 8'h0C; // f
         8'h76:   esc_code = 8'h0B; // v
         8'h45:   esc_code = 8'h1B; // E
         8'h65:   esc_code = 8'h1B; // e
         8'h5C:   esc_code = 8'h5C; // backslash
         default: esc_hit  = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      mode_mid = mode_ff;
      oct_mid  = oct_ff;
      case (mode_ff)
         bed_pkg::MODE_NORMAL: begin
            if (in_byte == bed_pkg::CHAR_BSLASH) mode_mid = bed_pkg::MODE_ESC;
         end
         bed_pkg::MODE_ESC: begin
            if (esc_hit) begin
               mode_mid = bed_pkg::MODE_NORMAL;
            end else if (is_oct) begin
               mode_mid = bed_pkg::MODE_OCT1;
               oct_mid  = {5'd0, in_byte[2:0]};
            end else begin
               mode_mid = bed_pkg::MODE_NORMAL;
            end
         end
         bed_pkg::MODE_OCT1: begin
            if (is_oct) begin
               mode_mid = bed_pkg::MODE_OCT2;
               oct_mid  = acc;
            end else begin
               oct_mid  = 8'h00;
               mode_mid = (in_byte == bed_pkg::CHAR_BSLASH) ? bed_pkg::MODE_ESC
                                                             : bed_pkg::MODE_NORMAL;
            end
         end
         bed_pkg::MODE_OCT2: begin
            oct_mid = 8'h00;
            if (is_oct) begin
               mode_mid = bed_pkg::MODE_NORMAL;
            end else begin
               mode_mid = (in_byte == bed_pkg::CHAR_BSLASH) ? bed_pkg::MODE_ESC
                                                             : bed_pkg::MODE_NORMAL;
            end
         end
         default: mode_mid = bed_pkg::MODE_NORMAL;
      endcase
      if (in_final) begin
         mode_in = bed_pkg::MODE_NORMAL;
         oct_in  = 8'h00;
      end else begin
         mode_in = mode_mid;
         oct_in  = oct_mid;
      end
   end

   // outputs
   always_comb begin
      bank = '0;
      case (mode_ff)
         bed_pkg::MODE_NORMAL: begin
            if (in_byte != bed_pkg::CHAR_BSLASH) bank = push(bank, in_byte, 1'b0);
         end
         bed_pkg::MODE_ESC: begin
            if (esc_hit) begin
               bank = push(bank, esc_code, 1'b0);
            end else if (!is_oct) begin
               bank = push(bank, 8'h00, 1'b1);
            end
         end
         bed_pkg::MODE_OCT1, bed_pkg::MODE_OCT2: begin
            if (!is_oct) begin
               bank = push(bank, oct_ff, 1'b0);
               if (in_byte != bed_pkg::CHAR_BSLASH) bank = push(bank, in_byte, 1'b0);
            end else if (mode_ff == bed_pkg::MODE_OCT2) begin
               bank = push(bank, acc, 1'b0);
            end
         end
         default: bank = '0;
      endcase
      if (in_final) begin
         if (mode_mid == bed_pkg::MODE_ESC) begin
            bank = push(bank, 8'h00, 1'b1);
         end else if (mode_mid == bed_pkg::MODE_OCT1 || mode_mid == bed_pkg::MODE_OCT2) begin
            bank = push(bank, oct_mid, 1'b0);
         end
         if (bank.cnt == 2'd1) bank.item[0].eos = 1'b1;
         if (bank.cnt == 2'd2) bank.item[1].eos = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bed_pkg::MODE_NORMAL;
         oct_ff  <= 8'h00;
      end else if (in_valid) begin
         mode_ff <= mode_in;
         oct_ff  <= oct_in;
      end
   end

endmodule

// ===== rtl/backslash_escape_decoder.sv =====
// Top level of the backslash escape decoder: decode stage plus result queue.
// Depends on bed_pkg and bed_decode.
//
// Usage:
//  - req channel: one string byte per word in req_tdata, req_tlast on the
//    final byte of a string.
//  - rsp channel: decoded byte in rsp_tdata, rsp_tuser flags a malformed
//    escape (data is then zero), rsp_tlast marks the last result of a string.
//  - Each input word yields zero, one or two result words. Results are
//    written into the result queue when the input word is taken.
//  - Throughput is one word per cycle while req_tready is high; the
//    four-entry result queue takes a new word whenever it has room for two
//    results, and a word that yields two results needs two rsp transfers.
//  - When rsp stalls, results collect in the queue and req_tready drops once
//    fewer than two entries are free; nothing is lost.
//  - Synchronous reset returns the decoder to pass-through mode and empties
//    the queue.
module backslash_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] in_byte
   input  logic       req_tlast,  // is_final
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] out_byte
   output logic       rsp_tuser,  // [0] error
   output logic       rsp_tlast   // end_of_string
);

   bed_pkg::bank_type bank;
   bed_pkg::rslt_type queue_ff [4];
   logic [1:0]        wr_ptr_ff, wr_ptr_in;
   logic [1:0]        rd_ptr_ff, rd_ptr_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              accept, pop;
   logic [1:0]        push_n;

   assign req_tready = cnt_ff < 3'd3;
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = cnt_ff != 3'd0;
   assign pop        = rsp_tvalid & rsp_tready;
   assign push_n     = accept ? bank.cnt : 2'd0;

   bed_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_byte  (req_tdata),
      .in_final (req_tlast),
      .bank     (bank)
   );

   assign wr_ptr_in = wr_ptr_ff + push_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign cnt_in    = cnt_ff + {1'b0, push_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) queue_ff[wr_ptr_ff] <= bank.item[0];
      if (push_n == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= bank.item[1];
   end

   assign rsp_tdata = queue_ff[rd_ptr_ff].data;
   assign rsp_tuser = queue_ff[rd_ptr_ff].err;
   assign rsp_tlast = queue_ff[rd_ptr_ff].eos;

endmodule
